/* rtl/core/lpai_pkg.sv */
// ----------------------------------------------------------------------------
// Log-polar angular index package
// Shared widths, codes, item records and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
package lpai_pkg;

    localparam int ANGLE_BITS   = 16;
    localparam int CORDIC_STEPS = 24;
    localparam int CW           = 40;   // CORDIC x/y datapath width
    localparam int MAX_RINGS    = 256;
    localparam int MAX_SECTORS  = 256;
    localparam int MAX_FOVEA    = 64;
    localparam int PAD_DEPTH    = MAX_FOVEA * MAX_SECTORS;
    localparam int PAD_AW       = $clog2(PAD_DEPTH);
    localparam int REM_W        = 10;   // signed remainder in [-2S, 2S)

    localparam logic [1:0] OP_COMPUTE   = 2'd0;
    localparam logic [1:0] OP_WR_SHIFT  = 2'd1;
    localparam logic [1:0] OP_WR_PAD    = 2'd2;

    localparam logic REG_SECTORS = 1'b0;
    localparam logic REG_FOVEA   = 1'b1;

    localparam logic [31:0] ATAN_TAB [CORDIC_STEPS] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81
    };

    // Side information that rides along the CORDIC chain.
    typedef struct packed {
        logic        valid;
        logic [1:0]  op;
        logic [7:0]  ring;
        logic [7:0]  column;
        logic [15:0] word;
        logic [15:0] shift;
        logic        origin;
    } t_tag;

    // Record that rides along the remainder chain.
    typedef struct packed {
        logic                    valid;
        logic                    is_res;
        logic                    fovea;
        logic                    flag;
        logic [7:0]              theta;
        logic [15:0]             entry;
        logic signed [REM_W-1:0] rem;
    } t_post;

endpackage

/* rtl/core/lpai_stream_if.sv */
// ----------------------------------------------------------------------------
// Log-polar angular index stream interfaces
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
interface lpai_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         op;
    logic signed [15:0] x_pos;
    logic signed [15:0] y_pos;
    logic [7:0]         ring;
    logic [7:0]         column;
    logic [15:0]        word;

    modport source (output valid, op, x_pos, y_pos, ring, column, word, input ready);
    modport sink   (input valid, op, x_pos, y_pos, ring, column, word, output ready);
endinterface

interface lpai_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] sector;
    logic       fovea_overflow;

    modport source (output valid, sector, fovea_overflow, input ready);
    modport sink   (input valid, sector, fovea_overflow, output ready);
endinterface

/* rtl/core/log_polar_angular_index_top.sv */
// ----------------------------------------------------------------------------
// Log-polar angular index top level
// Throughput: one transaction per cycle while the skid register is empty,
// set by the 24-cell CORDIC chain and the 15-cell remainder chain, all cells
// advancing together.
// Reset: synchronous, active low; clears the control registers and loads the
// config registers with 252 sectors and 42 fovea rings. The ring shift and
// padding tables are undefined until written.
// ----------------------------------------------------------------------------
module log_polar_angular_index_top
    import lpai_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    lpai_in_if.sink     i_in,
    lpai_out_if.source  o_out,
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic [2:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    output logic [31:0] o_prdata,
    output logic        o_pready
);

    localparam int MOD_CELLS = 15;

    // Configuration registers. Register index is address bit 2; the low
    // address bits are ignored.
    logic [8:0] r_spr;
    logic [6:0] r_fov;
    logic [8:0] s_eff;
    logic [6:0] f_eff;

    assign o_pready = 1'b1;
    assign o_prdata = (i_paddr[2] == REG_FOVEA) ? {25'd0, r_fov} : {23'd0, r_spr};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_spr <= 9'd252;
            r_fov <= 7'd42;
        end else if (i_psel && i_penable && i_pwrite) begin
            if (i_paddr[2] == REG_SECTORS) begin
                r_spr <= i_pwdata[8:0];
            end else begin
                r_fov <= i_pwdata[6:0];
            end
        end
    end

    // Out-of-range settings are clamped to the supported range.
    always_comb begin
        if (r_spr < 9'd2) begin
            s_eff = 9'd2;
        end else if (r_spr > 9'(MAX_SECTORS)) begin
            s_eff = 9'(MAX_SECTORS);
        end else begin
            s_eff = r_spr;
        end
        f_eff = (r_fov > 7'(MAX_FOVEA)) ? 7'(MAX_FOVEA) : r_fov;
    end

    // The whole pipeline advances in lockstep whenever the skid register is
    // empty, so the input stays ready while a finished result waits.
    logic r_skid_v;
    logic en;

    assign en         = !r_skid_v;
    assign i_in.ready = en;

    // Input stage and ring shift memory. The shift is read at accept time so
    // the registered read data lines up with the captured transaction.
    logic [15:0]        r_shift_mem [MAX_RINGS];
    logic [15:0]        r_shift_rd;
    logic               r_s0_v;
    logic [1:0]         r_s0_op;
    logic signed [15:0] r_s0_x;
    logic signed [15:0] r_s0_y;
    logic [7:0]         r_s0_ring;
    logic [7:0]         r_s0_col;
    logic [15:0]        r_s0_word;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_shift_rd <= r_shift_mem[i_in.ring];
            if (i_in.valid && i_in.op == OP_WR_SHIFT) begin
                r_shift_mem[i_in.ring] <= i_in.word;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_v <= 1'b0;
        end else if (en) begin
            r_s0_v <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s0_op   <= i_in.op;
            r_s0_x    <= i_in.x_pos;
            r_s0_y    <= i_in.y_pos;
            r_s0_ring <= i_in.ring;
            r_s0_col  <= i_in.column;
            r_s0_word <= i_in.word;
        end
    end

    // CORDIC entry: vector (-x, y), folded into the right half plane.
    t_tag                 c_tag [CORDIC_STEPS+1];
    logic signed [CW-1:0] c_x   [CORDIC_STEPS+1];
    logic signed [CW-1:0] c_y   [CORDIC_STEPS+1];
    logic [31:0]          c_z   [CORDIC_STEPS+1];
    logic signed [16:0]   xa;
    logic signed [16:0]   ya;

    assign xa = -(17'(r_s0_x));
    assign ya = 17'(r_s0_y);

    always_comb begin
        c_tag[0].valid  = r_s0_v;
        c_tag[0].op     = r_s0_op;
        c_tag[0].ring   = r_s0_ring;
        c_tag[0].column = r_s0_col;
        c_tag[0].word   = r_s0_word;
        c_tag[0].shift  = r_shift_rd;
        c_tag[0].origin = (xa == 17'sd0) && (ya == 17'sd0);
        if (xa < 0) begin
            c_x[0] = CW'(-xa) <<< 20;
            c_y[0] = CW'(-ya) <<< 20;
            c_z[0] = 32'h8000_0000;
        end else begin
            c_x[0] = CW'(xa) <<< 20;
            c_y[0] = CW'(ya) <<< 20;
            c_z[0] = 32'd0;
        end
    end

    for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cordic
        lpai_cordic_cell #(.STEP(g)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_tag   (c_tag[g]),
            .i_cx    (c_x[g]),
            .i_cy    (c_y[g]),
            .i_z     (c_z[g]),
            .o_tag   (c_tag[g+1]),
            .o_cx    (c_x[g+1]),
            .o_cy    (c_y[g+1]),
            .o_z     (c_z[g+1])
        );
    end

    // Stage P1: round the angle, apply half turn and ring shift, classify
    // the ring and form ring * sectors for the padding table address.
    t_tag        last_tag;
    logic [31:0] z_rnd;
    logic [15:0] atan_bau;
    t_tag        r_p1_tag;
    logic [15:0] r_p1_angle;
    logic        r_p1_fovea;
    logic [16:0] r_p1_base;

    assign last_tag = c_tag[CORDIC_STEPS];
    assign z_rnd    = c_z[CORDIC_STEPS] + 32'(1 << (31 - ANGLE_BITS));
    assign atan_bau = last_tag.origin ? 16'h8000 : z_rnd[31:32-ANGLE_BITS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_tag.valid <= 1'b0;
        end else if (en) begin
            r_p1_tag.valid <= last_tag.valid;
        end
        if (en) begin
            r_p1_tag.op     <= last_tag.op;
            r_p1_tag.ring   <= last_tag.ring;
            r_p1_tag.column <= last_tag.column;
            r_p1_tag.word   <= last_tag.word;
            r_p1_tag.shift  <= last_tag.shift;
            r_p1_tag.origin <= last_tag.origin;
            r_p1_angle      <= 16'h8000 - atan_bau - last_tag.shift;
            r_p1_fovea      <= {1'b0, last_tag.ring} < {2'b0, f_eff};
            r_p1_base       <= 17'(last_tag.ring * s_eff);
        end
    end

    // Stage P2: one multiply, by 6*ring for fovea rings, else by sectors.
    logic [10:0] mult;
    logic [26:0] prod;
    t_tag        r_p2_tag;
    logic        r_p2_fovea;
    logic [16:0] r_p2_base;
    logic [10:0] r_p2_val;

    assign mult = r_p1_fovea ? 11'(r_p1_tag.ring * 4'd6) : {2'b0, s_eff};
    assign prod = r_p1_angle * mult;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p2_tag.valid <= 1'b0;
        end else if (en) begin
            r_p2_tag.valid <= r_p1_tag.valid;
        end
        if (en) begin
            r_p2_tag.op     <= r_p1_tag.op;
            r_p2_tag.ring   <= r_p1_tag.ring;
            r_p2_tag.column <= r_p1_tag.column;
            r_p2_tag.word   <= r_p1_tag.word;
            r_p2_tag.shift  <= r_p1_tag.shift;
            r_p2_tag.origin <= r_p1_tag.origin;
            r_p2_fovea      <= r_p1_fovea;
            r_p2_base       <= r_p1_base;
            r_p2_val        <= prod[26:16];
        end
    end

    // Stage P3: padding table access. Writes and reads share this stage, so
    // they take effect in transaction order.
    logic [15:0]       r_pad_mem [PAD_DEPTH];
    logic [15:0]       r_pad_rd;
    logic [PAD_AW-1:0] rd_addr;
    logic [PAD_AW-1:0] wr_addr;
    logic [16:0]       rd_sum;
    logic [16:0]       wr_sum;
    logic [10:0]       outer_fix;
    t_post             r_p3;

    assign rd_sum    = r_p2_base + 17'(r_p2_val);
    assign wr_sum    = r_p2_base + 17'(r_p2_tag.column);
    assign rd_addr   = rd_sum[PAD_AW-1:0];
    assign wr_addr   = wr_sum[PAD_AW-1:0];
    assign outer_fix = (r_p2_val >= {2'b0, s_eff}) ? r_p2_val - {2'b0, s_eff} : r_p2_val;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_pad_rd <= r_pad_mem[rd_addr];
            if (r_p2_tag.valid && r_p2_tag.op == OP_WR_PAD) begin
                r_pad_mem[wr_addr] <= r_p2_tag.word;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p3.valid <= 1'b0;
        end else if (en) begin
            r_p3.valid <= r_p2_tag.valid;
        end
        if (en) begin
            r_p3.is_res <= (r_p2_tag.op == OP_COMPUTE);
            r_p3.fovea  <= r_p2_fovea;
            r_p3.flag   <= r_p2_fovea && (r_p2_val >= {2'b0, s_eff});
            r_p3.theta  <= outer_fix[7:0];
            r_p3.entry  <= 16'd0;
            r_p3.rem    <= '0;
        end
    end

    // Remainder chain: floor modulo of the signed table entry by sectors,
    // one entry bit per cell, starting from the sign.
    t_post m_post [MOD_CELLS+1];

    always_comb begin
        m_post[0]       = r_p3;
        m_post[0].entry = r_pad_rd;
        m_post[0].rem   = r_pad_rd[15] ? -(REM_W'(1)) : '0;
    end

    for (genvar g = 0; g < MOD_CELLS; g++) begin : g_mod
        lpai_mod_cell #(.BIT(MOD_CELLS - 1 - g)) u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_en      (en),
            .i_sectors (s_eff),
            .i_post    (m_post[g]),
            .o_post    (m_post[g+1])
        );
    end

    // Output register plus one skid register.
    t_post      fin;
    logic       res_v;
    logic [7:0] res_sector;
    logic       res_flag;
    logic       r_out_v;
    logic [7:0] r_out_sector;
    logic       r_out_flag;
    logic       r_out_fovea;
    logic [7:0] r_skid_sector;
    logic       r_skid_flag;
    logic       r_skid_fovea;

    assign fin        = m_post[MOD_CELLS];
    assign res_v      = en && fin.valid && fin.is_res;
    assign res_sector = fin.fovea ? fin.rem[7:0] : fin.theta;
    assign res_flag   = fin.fovea && fin.flag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (!r_out_v || o_out.ready) begin
            if (r_skid_v) begin
                r_out_v  <= 1'b1;
                r_skid_v <= 1'b0;
            end else begin
                r_out_v  <= res_v;
            end
        end else if (res_v) begin
            r_skid_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_v || o_out.ready) begin
            if (r_skid_v) begin
                r_out_sector <= r_skid_sector;
                r_out_flag   <= r_skid_flag;
                r_out_fovea  <= r_skid_fovea;
            end else begin
                r_out_sector <= res_sector;
                r_out_flag   <= res_flag;
                r_out_fovea  <= fin.fovea;
            end
        end else if (res_v) begin
            r_skid_sector <= res_sector;
            r_skid_flag   <= res_flag;
            r_skid_fovea  <= fin.fovea;
        end
    end

    assign o_out.valid          = r_out_v;
    assign o_out.sector         = r_out_sector;
    assign o_out.fovea_overflow = r_out_flag;

    // The skid register only fills behind a stalled output register.
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v |-> r_out_v)
        else $error("skid register holds a result while the output is empty");

    // Only fovea lookups can raise the overflow flag.
    a_flag_fovea: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_v && !r_out_fovea) |-> !r_out_flag)
        else $error("overflow flag on an outer ring result");

    // Every delivered sector lies below the effective sector count.
    a_sector_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_v |-> ({1'b0, r_out_sector} < s_eff))
        else $error("sector index out of range");

    // A stalled result with a full skid register blocks input acceptance.
    a_stall_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_v && !o_out.ready) |=> !i_in.ready)
        else $error("input accepted while both result registers are full");

endmodule

/* rtl/core/lpai_cordic_cell.sv */
// ----------------------------------------------------------------------------
// Log-polar angular index CORDIC cell
// One vectoring rotation step with a fixed shift, registered.
// ----------------------------------------------------------------------------
module lpai_cordic_cell
    import lpai_pkg::*;
#(
    parameter int STEP = 0
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  t_tag                 i_tag,
    input  logic signed [CW-1:0] i_cx,
    input  logic signed [CW-1:0] i_cy,
    input  logic [31:0]          i_z,
    output t_tag                 o_tag,
    output logic signed [CW-1:0] o_cx,
    output logic signed [CW-1:0] o_cy,
    output logic [31:0]          o_z
);

    logic signed [CW-1:0] dx;
    logic signed [CW-1:0] dy;
    logic signed [CW-1:0] n_cx;
    logic signed [CW-1:0] n_cy;
    logic [31:0]          n_z;

    assign dx = i_cy >>> STEP;
    assign dy = i_cx >>> STEP;

    always_comb begin
        if (!i_cy[CW-1]) begin
            n_cx = i_cx + dx;
            n_cy = i_cy - dy;
            n_z  = i_z + ATAN_TAB[STEP];
        end else begin
            n_cx = i_cx - dx;
            n_cy = i_cy + dy;
            n_z  = i_z - ATAN_TAB[STEP];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_tag.valid <= 1'b0;
        end else if (i_en) begin
            o_tag.valid <= i_tag.valid;
        end
        if (i_en) begin
            o_tag.op     <= i_tag.op;
            o_tag.ring   <= i_tag.ring;
            o_tag.column <= i_tag.column;
            o_tag.word   <= i_tag.word;
            o_tag.shift  <= i_tag.shift;
            o_tag.origin <= i_tag.origin;
            o_cx         <= n_cx;
            o_cy         <= n_cy;
            o_z          <= n_z;
        end
    end

endmodule

/* rtl/core/lpai_mod_cell.sv */
// ----------------------------------------------------------------------------
// Log-polar angular index remainder cell
// One restoring step of a floor modulo by the sector count, registered.
// ----------------------------------------------------------------------------
module lpai_mod_cell
    import lpai_pkg::*;
#(
    parameter int BIT = 0
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_en,
    input  logic [8:0] i_sectors,
    input  t_post      i_post,
    output t_post      o_post
);

    logic signed [REM_W-1:0] dbl;
    logic signed [REM_W-1:0] s_ext;
    logic signed [REM_W-1:0] n_rem;

    assign s_ext = REM_W'(i_sectors);
    assign dbl   = (i_post.rem <<< 1) | REM_W'(i_post.entry[BIT]);

    always_comb begin
        if (dbl < 0) begin
            n_rem = dbl + s_ext;
        end else if (dbl >= s_ext) begin
            n_rem = dbl - s_ext;
        end else begin
            n_rem = dbl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_post.valid <= 1'b0;
        end else if (i_en) begin
            o_post.valid <= i_post.valid;
        end
        if (i_en) begin
            o_post.is_res <= i_post.is_res;
            o_post.fovea  <= i_post.fovea;
            o_post.flag   <= i_post.flag;
            o_post.theta  <= i_post.theta;
            o_post.entry  <= i_post.entry;
            o_post.rem    <= n_rem;
        end
    end

endmodule
